/* design/ray_sphere_intersect_macros.svh */
// Assertion macros shared by the ray-sphere intersection block.
`ifndef RAY_SPHERE_INTERSECT_MACROS_SVH
`define RAY_SPHERE_INTERSECT_MACROS_SVH

// Same-cycle implication on aclk, disabled while aresetn is low.
`define RSI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on aclk, disabled while aresetn is low.
`define RSI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rsi_pkg.sv */
// Shared widths and types for the ray-sphere intersection block.
package rsi_pkg;

    localparam int MAG_W   = 40;           // magnitude of closest-point offset
    localparam int LO_W    = 32;           // low slice of the squarer split
    localparam int HI_W    = MAG_W - LO_W; // high slice of the squarer split
    localparam int SQ_W    = 2 * MAG_W;    // square of one offset
    localparam int NSTAGE  = 9;            // pipeline depth, accept to output

    // Stage enables handed to the squarer.
    typedef struct packed {
        logic a;   // partial products
        logic b;   // combine
    } sq_en_t;

endpackage

/* design/rsi_square.sv */
// Two-stage pipelined squarer for a 40-bit magnitude, split into 32x32 and narrow products.
module rsi_square (
    input  logic                       aclk,
    input  rsi_pkg::sq_en_t            en,
    input  logic [rsi_pkg::MAG_W-1:0]  mag,
    output logic [rsi_pkg::SQ_W-1:0]   sq
);

    logic [2*rsi_pkg::LO_W-1:0]            ll_reg;
    logic [rsi_pkg::HI_W+rsi_pkg::LO_W-1:0] hl_reg;
    logic [2*rsi_pkg::HI_W-1:0]            hh_reg;
    logic [rsi_pkg::SQ_W-1:0]              sq_reg;
    logic [rsi_pkg::SQ_W-1:0]              sq_next;

    logic [rsi_pkg::LO_W-1:0] lo;
    logic [rsi_pkg::HI_W-1:0] hi;

    assign lo = mag[rsi_pkg::LO_W-1:0];
    assign hi = mag[rsi_pkg::MAG_W-1:rsi_pkg::LO_W];

    always_ff @(posedge aclk) begin
        if (en.a) begin
            ll_reg <= lo * lo;
            hl_reg <= hi * lo;
            hh_reg <= hi * hi;
        end
    end

    // m^2 = hh<<64 + 2*hl<<32 + ll
    always_comb begin
        sq_next = {hh_reg, {(2*rsi_pkg::LO_W){1'b0}}}
                + rsi_pkg::SQ_W'({hl_reg, {(rsi_pkg::LO_W+1){1'b0}}})
                + rsi_pkg::SQ_W'(ll_reg);
    end

    always_ff @(posedge aclk) begin
        if (en.b) begin
            sq_reg <= sq_next;
        end
    end

    assign sq = sq_reg;

endmodule

/* design/ray_sphere_intersect.sv */
// Ray-sphere closest-point intersection: nine-stage pipeline, one word per cycle while the output is not stalled.
// An accepted word sets vld_reg[0], and its valid bit passes stage by stage up to vld_reg[8],
// which drives m_axis_tvalid; the result is taken when m_axis_tready is also high.
// Throughput: one word per cycle; each stage holds one word and moves when the next
// stage is empty or moving, so bubbles fill and a stalled output backs up stage by stage.
// Depth is set by the chained 33x16 and 37x16 multiplies and the split 40-bit squarer.
// Reset (aresetn low, synchronous) clears the stage valid bits only.
`include "ray_sphere_intersect_macros.svh"

module ray_sphere_intersect (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // center_x[31:0] center_y[63:32] center_z[95:64] sphere_radius[126:96]
    // origin_x[158:127] origin_y[190:159] origin_z[222:191]
    // dir_x[238:223] dir_y[254:239] dir_z[270:255] ray_length[301:271], zero pad
    input  logic [303:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit[0] hit_distance[31:1] within_radius[32], zero pad
    output logic [39:0]  m_axis_tdata
);

    localparam logic [36:0] DIST_MAX = 37'h0_7FFF_FFFF;

    // ---- handshake: per-stage valid and enable
    logic [rsi_pkg::NSTAGE-1:0] vld_reg;
    logic [rsi_pkg::NSTAGE-1:0] vld_next;
    logic [rsi_pkg::NSTAGE-1:0] stg_en;

    assign stg_en[rsi_pkg::NSTAGE-1] = !vld_reg[rsi_pkg::NSTAGE-1] || m_axis_tready;
    genvar g;
    generate
        for (g = 0; g < rsi_pkg::NSTAGE-1; g++) begin : g_en
            assign stg_en[g] = !vld_reg[g] || stg_en[g+1];
        end
    endgenerate

    always_comb begin
        vld_next[0] = stg_en[0] ? s_axis_tvalid : vld_reg[0];
        for (int k = 1; k < rsi_pkg::NSTAGE; k++) begin
            vld_next[k] = stg_en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_axis_tready = stg_en[0];
    assign m_axis_tvalid = vld_reg[rsi_pkg::NSTAGE-1];

    // ---- input fields
    logic signed [31:0] c_in [0:2];
    logic signed [31:0] o_in [0:2];
    logic signed [15:0] d_in [0:2];
    logic        [30:0] rad_in;
    logic        [30:0] len_in;

    assign c_in[0] = s_axis_tdata[31:0];
    assign c_in[1] = s_axis_tdata[63:32];
    assign c_in[2] = s_axis_tdata[95:64];
    assign rad_in  = s_axis_tdata[126:96];
    assign o_in[0] = s_axis_tdata[158:127];
    assign o_in[1] = s_axis_tdata[190:159];
    assign o_in[2] = s_axis_tdata[222:191];
    assign d_in[0] = s_axis_tdata[238:223];
    assign d_in[1] = s_axis_tdata[254:239];
    assign d_in[2] = s_axis_tdata[270:255];
    assign len_in  = s_axis_tdata[301:271];

    // ---- stage 0: v = center - origin
    logic signed [32:0] v1_reg [0:2];
    logic signed [15:0] d1_reg [0:2];
    logic        [30:0] rad1_reg, len1_reg;

    always_ff @(posedge aclk) begin
        if (stg_en[0]) begin
            for (int i = 0; i < 3; i++) begin
                v1_reg[i] <= 33'(c_in[i]) - 33'(o_in[i]);
                d1_reg[i] <= d_in[i];
            end
            rad1_reg <= rad_in;
            len1_reg <= len_in;
        end
    end

    // ---- stage 1: p = v * dir
    logic signed [48:0] p2_reg [0:2];
    logic signed [32:0] v2_reg [0:2];
    logic signed [15:0] d2_reg [0:2];
    logic        [30:0] rad2_reg, len2_reg;

    always_ff @(posedge aclk) begin
        if (stg_en[1]) begin
            for (int i = 0; i < 3; i++) begin
                p2_reg[i] <= v1_reg[i] * d1_reg[i];
                v2_reg[i] <= v1_reg[i];
                d2_reg[i] <= d1_reg[i];
            end
            rad2_reg <= rad1_reg;
            len2_reg <= len1_reg;
        end
    end

    // ---- stage 2: t = floor(dot / 2^14)
    logic signed [50:0] dot_next;
    logic signed [36:0] t3_reg;
    logic signed [32:0] v3_reg [0:2];
    logic signed [15:0] d3_reg [0:2];
    logic        [30:0] rad3_reg, len3_reg;

    assign dot_next = 51'(p2_reg[0]) + 51'(p2_reg[1]) + 51'(p2_reg[2]);

    always_ff @(posedge aclk) begin
        if (stg_en[2]) begin
            t3_reg <= dot_next[50:14];
            for (int i = 0; i < 3; i++) begin
                v3_reg[i] <= v2_reg[i];
                d3_reg[i] <= d2_reg[i];
            end
            rad3_reg <= rad2_reg;
            len3_reg <= len2_reg;
        end
    end

    // ---- stage 3: q = t * dir, |t|
    logic signed [52:0] q4_reg [0:2];
    logic signed [32:0] v4_reg [0:2];
    logic        [36:0] at4_reg;
    logic        [30:0] rad4_reg, len4_reg;

    always_ff @(posedge aclk) begin
        if (stg_en[3]) begin
            for (int i = 0; i < 3; i++) begin
                q4_reg[i] <= t3_reg * d3_reg[i];
                v4_reg[i] <= v3_reg[i];
            end
            at4_reg  <= t3_reg[36] ? 37'(-t3_reg) : 37'(t3_reg);
            rad4_reg <= rad3_reg;
            len4_reg <= len3_reg;
        end
    end

    // ---- stage 4: e = floor(q / 2^14) - v, |e|
    logic signed [rsi_pkg::MAG_W-1:0] e_next [0:2];
    logic        [rsi_pkg::MAG_W-1:0] m5_reg [0:2];
    logic        [36:0] at5_reg;
    logic        [30:0] rad5_reg, len5_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e_next[i] = rsi_pkg::MAG_W'($signed(q4_reg[i][52:14]))
                      - rsi_pkg::MAG_W'(v4_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_en[4]) begin
            for (int i = 0; i < 3; i++) begin
                m5_reg[i] <= e_next[i][rsi_pkg::MAG_W-1] ? -e_next[i] : e_next[i];
            end
            at5_reg  <= at4_reg;
            rad5_reg <= rad4_reg;
            len5_reg <= len4_reg;
        end
    end

    // ---- stages 5 and 6: squares of |e|, radius squared
    rsi_pkg::sq_en_t            sq_en;
    logic [rsi_pkg::SQ_W-1:0]   sq7 [0:2];
    logic [61:0]                r2_6_reg, r2_7_reg;
    logic [36:0]                at6_reg, at7_reg;
    logic [30:0]                len6_reg, len7_reg;

    assign sq_en.a = stg_en[5];
    assign sq_en.b = stg_en[6];

    generate
        for (g = 0; g < 3; g++) begin : g_sq
            rsi_square u_sq (
                .aclk (aclk),
                .en   (sq_en),
                .mag  (m5_reg[g]),
                .sq   (sq7[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (stg_en[5]) begin
            r2_6_reg <= rad5_reg * rad5_reg;
            at6_reg  <= at5_reg;
            len6_reg <= len5_reg;
        end
        if (stg_en[6]) begin
            r2_7_reg <= r2_6_reg;
            at7_reg  <= at6_reg;
            len7_reg <= len6_reg;
        end
    end

    // ---- stage 7: squared closest distance
    logic [rsi_pkg::SQ_W+1:0] dist2_8_reg;
    logic [61:0]              r2_8_reg;
    logic [36:0]              at8_reg;
    logic [30:0]              len8_reg;

    always_ff @(posedge aclk) begin
        if (stg_en[7]) begin
            dist2_8_reg <= (rsi_pkg::SQ_W+2)'(sq7[0]) + (rsi_pkg::SQ_W+2)'(sq7[1])
                         + (rsi_pkg::SQ_W+2)'(sq7[2]);
            r2_8_reg    <= r2_7_reg;
            at8_reg     <= at7_reg;
            len8_reg    <= len7_reg;
        end
    end

    // ---- stage 8: decisions, output word
    logic        within_next;
    logic        hit_reg, within_reg;
    logic [30:0] dist_reg;

    assign within_next = dist2_8_reg <= (rsi_pkg::SQ_W+2)'(r2_8_reg);

    always_ff @(posedge aclk) begin
        if (stg_en[8]) begin
            within_reg <= within_next;
            hit_reg    <= within_next && (at8_reg <= 37'(len8_reg));
            if (!within_next) begin
                dist_reg <= '0;
            end else if (at8_reg > DIST_MAX) begin
                dist_reg <= DIST_MAX[30:0];
            end else begin
                dist_reg <= at8_reg[30:0];
            end
        end
    end

    assign m_axis_tdata = {7'b0, within_reg, dist_reg, hit_reg};

    // ---- checks
    `RSI_ASSERT_IMP(a_hit_within, m_axis_tvalid && hit_reg, within_reg, "hit without within")
    `RSI_ASSERT_IMP(a_miss_zero, m_axis_tvalid && !within_reg, dist_reg == 31'd0, "miss distance")
    `RSI_ASSERT_IMP(a_full_stall, !s_axis_tready, (&vld_reg) && !m_axis_tready, "stall not full")
    `RSI_ASSERT_NXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_reg[0], "word lost")

endmodule
